// ----- hdl/fcgl_pkg.sv -----
// shared types and constants for the character-map glyph lookup
// no dependencies
package fcgl_pkg;
  localparam int TableBytes = 4096;
  localparam int AddrW = $clog2(TableBytes);
  localparam int LenW = AddrW + 1;
  localparam logic [15:0] FmtSegment = 16'd4;
  localparam logic [15:0] FmtGroup = 16'd12;

  typedef enum logic [1:0] {
    RD_NONE = 2'd0,
    RD_B16 = 2'd1,
    RD_B32 = 2'd2
  } rd_kind_t;

  // datapath command from the controller
  typedef struct packed {
    logic            rd_go;
    logic [1:0]      rd_bytes;  // bytes minus one
    logic [AddrW-1:0] rd_addr;
    logic            wr_en;
  } dp_cmd_t;

  typedef struct packed {
    logic        rd_done;
    logic [31:0] rd_data;
  } dp_stat_t;
endpackage

// ----- hdl/fcgl_store.sv -----
// byte store with a multi-byte big-endian read sequencer
// depends on fcgl_pkg
module fcgl_store
  import fcgl_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  dp_cmd_t          cmd,
  input  logic [AddrW-1:0] wr_addr,
  input  logic [7:0]       wr_data,
  output dp_stat_t         stat
);
  logic [7:0] mem [TableBytes];
  logic [7:0] rd_q;
  logic [AddrW-1:0] ptr;
  logic [1:0] left;
  logic busy;
  logic issued;
  logic [31:0] acc;

  always_ff @(posedge clk) begin
    if (cmd.wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_q <= mem[ptr];
  end

  // reads one byte at a time through the registered rd_q; rd_go is ignored while busy
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      issued <= 1'b0;
      stat.rd_done <= 1'b0;
    end else begin
      stat.rd_done <= 1'b0;
      if (cmd.rd_go && !busy) begin
        busy <= 1'b1;
        issued <= 1'b0;
        ptr <= cmd.rd_addr;
        left <= cmd.rd_bytes;
        acc <= '0;
      end else if (busy) begin
        if (!issued) begin
          issued <= 1'b1;
        end else begin
          acc <= {acc[23:0], rd_q};
          if (left == 2'd0) begin
            busy <= 1'b0;
            stat.rd_done <= 1'b1;
            stat.rd_data <= {acc[23:0], rd_q};
          end else begin
            left <= left - 2'd1;
            ptr <= ptr + 1'b1;
            issued <= 1'b0;
          end
        end
      end
    end
  end
endmodule

// ----- hdl/fcgl_ctrl.sv -----
// lookup sequencer: walks the header, segments and groups through the store
// depends on fcgl_pkg
module fcgl_ctrl
  import fcgl_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  input  logic          go,
  input  logic [20:0]   cp,
  input  logic [LenW:0] len,
  input  dp_stat_t      stat,
  output dp_cmd_t       cmd,
  output logic          done,
  output logic [31:0]   glyph,
  output logic          bad
);
  typedef enum logic [10:0] {
    S_IDLE  = 11'b00000000001,
    S_FMT   = 11'b00000000010,
    S_HDR   = 11'b00000000100,
    S_END   = 11'b00000001000,
    S_START = 11'b00000010000,
    S_DELTA = 11'b00000100000,
    S_RANGE = 11'b00001000000,
    S_GARR  = 11'b00010000000,
    S_GST   = 11'b00100000000,
    S_GEND  = 11'b01000000000,
    S_GGLY  = 11'b10000000000
  } st_t;

  st_t st;
  logic is12;
  logic waiting;
  logic [31:0] hdr;    // seg2, group count, or glyph array address
  logic [31:0] off;    // segment or group byte offset
  logic [15:0] startc, delta;
  logic [31:0] gstart;
  logic [17:0] seg2x3;
  logic [33:0] gaddr;
  logic [36:0] need12;
  logic [LenW:0] lenc;
  logic [31:0] d;

  assign d = stat.rd_data;
  assign seg2x3 = {2'b0, hdr[15:0]} * 18'd3;
  assign need12 = {hdr, 2'b0} + {1'b0, hdr, 3'b0} + 37'd16;
  assign lenc = len;

  task automatic rd(input logic [33:0] a, input logic [1:0] n);
    cmd.rd_go = 1'b1;
    cmd.rd_addr = a[AddrW-1:0];
    cmd.rd_bytes = n;
  endtask

  always_comb begin
    cmd = '0;
    gaddr = 34'd16 + {16'b0, seg2x3} + {2'b0, off} + {18'b0, d[15:0]}
          + {12'b0, (cp - {5'b0, startc}), 1'b0};
    if (!waiting) begin
      case (st)
        S_FMT: rd(34'd0, 2'd1);
        S_HDR: rd(is12 ? 34'd12 : 34'd6, is12 ? 2'd3 : 2'd1);
        S_END: rd(is12 ? 34'd20 + {2'b0, off} : 34'd14 + {2'b0, off}, is12 ? 2'd3 : 2'd1);
        S_START: rd(34'd16 + {18'b0, hdr[15:0]} + {2'b0, off}, 2'd1);
        S_DELTA: rd(34'd16 + {17'b0, hdr[15:0], 1'b0} + {2'b0, off}, 2'd1);
        S_RANGE: rd(34'd16 + {16'b0, seg2x3} + {2'b0, off}, 2'd1);
        S_GARR: rd({2'b0, hdr}, 2'd1);
        S_GST: rd(34'd16 + {2'b0, off}, 2'd3);
        S_GGLY: rd(34'd24 + {2'b0, off}, 2'd3);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= S_IDLE;
      waiting <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cmd.rd_go) waiting <= 1'b1;
      if (stat.rd_done) waiting <= 1'b0;
      case (st)
        S_IDLE: if (go) begin
          glyph <= '0;
          bad <= 1'b0;
          off <= '0;
          if (len < 2) begin
            bad <= 1'b1;
            done <= 1'b1;
          end else st <= S_FMT;
        end
        S_FMT: if (stat.rd_done) begin
          is12 <= d[15:0] == FmtGroup;
          if (d[15:0] == FmtSegment && len < 8 || d[15:0] == FmtGroup && len < 16) begin
            bad <= 1'b1; done <= 1'b1; st <= S_IDLE;
          end else if (d[15:0] == FmtSegment || d[15:0] == FmtGroup) st <= S_HDR;
          else begin done <= 1'b1; st <= S_IDLE; end
        end
        S_HDR: if (stat.rd_done) begin
          hdr <= d;
          if (is12) begin
            if ({32'b0, lenc} < ({d, 2'b0} + {1'b0, d, 3'b0} + 37'd16)) begin
              bad <= 1'b1; done <= 1'b1; st <= S_IDLE;
            end else if (d == 0) begin done <= 1'b1; st <= S_IDLE; end
            else st <= S_GST;
          end else begin
            if ({5'b0, lenc} < {d[15:0], 2'b0} + 19'd16 || d[15:0] == 0) begin
              done <= 1'b1; st <= S_IDLE;
            end else st <= S_END;
          end
        end
        S_END: if (stat.rd_done) begin
          if (is12) begin
            if ({11'b0, cp} > d) begin
              if (off + 32'd12 >= need12[31:0] - 32'd16) begin done <= 1'b1; st <= S_IDLE; end
              else begin off <= off + 32'd12; st <= S_GST; end
            end else st <= S_GGLY;
          end else if (cp > {5'b0, d[15:0]}) begin
            if (off + 32'd2 >= {16'b0, hdr[15:0]}) begin done <= 1'b1; st <= S_IDLE; end
            else off <= off + 32'd2;
          end else st <= S_START;
        end
        S_START: if (stat.rd_done) begin
          startc <= d[15:0];
          if (cp < {5'b0, d[15:0]}) begin done <= 1'b1; st <= S_IDLE; end
          else st <= S_DELTA;
        end
        S_DELTA: if (stat.rd_done) begin delta <= d[15:0]; st <= S_RANGE; end
        S_RANGE: if (stat.rd_done) begin
          if (d[15:0] == 0) begin
            glyph <= {16'b0, cp[15:0] + delta};
            done <= 1'b1; st <= S_IDLE;
          end else if (gaddr + 34'd2 > {20'b0, lenc}) begin
            bad <= 1'b1; done <= 1'b1; st <= S_IDLE;
          end else begin hdr <= gaddr[31:0]; st <= S_GARR; end
        end
        S_GARR: if (stat.rd_done) begin
          glyph <= {16'b0, d[15:0] + delta};
          done <= 1'b1; st <= S_IDLE;
        end
        S_GST: if (stat.rd_done) begin
          gstart <= d;
          if ({11'b0, cp} < d) begin done <= 1'b1; st <= S_IDLE; end
          else st <= S_END;
        end
        S_GGLY: if (stat.rd_done) begin
          glyph <= {11'b0, cp} - gstart + d;
          done <= 1'b1; st <= S_IDLE;
        end
        default: st <= S_IDLE;
      endcase
    end
  end
endmodule

// ----- hdl/font_cmap_glyph_lookup_top.sv -----
// character-map glyph lookup: byte store plus segment/group scan, a load takes no busy cycle
// lookup: after acceptance the store reads the format, then the header; format 4 then reads
//   segment end codes until a hit, then its start code, delta, range offset and, if nonzero, glyphIdArray;
//   format 12 reads each group's start and end code until a hit, then that group's start glyph id
// one lookup at a time, busy falls the cycle after done; loads back to back while not busy
// reset: synchronous rst clears control and table_length; store undefined; results never stall
module font_cmap_glyph_lookup_top
  import fcgl_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic        mode,
  input  logic [11:0] byte_address,
  input  logic [7:0]  byte_value,
  input  logic [20:0] codepoint,
  output logic        done,
  output logic [31:0] glyph_id,
  output logic        malformed,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [12:0] cfg_data
);
  logic [12:0] table_length;
  logic [LenW:0] len;
  logic run;
  logic [20:0] cp;
  logic go;
  dp_cmd_t cmd, ccmd;
  dp_stat_t stat;

  assign cfg_ready = 1'b1;
  // effective length clipped to the store
  assign len = (table_length > 13'(TableBytes)) ? (LenW+1)'(TableBytes)
             : (LenW+1)'(table_length);

  always_ff @(posedge clk) begin
    if (rst) table_length <= '0;
    else if (cfg_valid && cfg_ready) table_length <= cfg_data;
  end

  // a lookup request holds busy until its done strobe
  always_ff @(posedge clk) begin
    if (rst) begin
      run <= 1'b0;
      go <= 1'b0;
    end else begin
      go <= start && !busy && mode;
      if (start && !busy && mode) begin
        run <= 1'b1;
        cp <= codepoint;
      end
      if (done) run <= 1'b0;
    end
  end
  assign busy = run;

  always_comb begin
    cmd = ccmd;
    cmd.wr_en = start && !busy && !mode;
  end

  fcgl_store u_store (
    .clk, .rst, .cmd,
    .wr_addr(byte_address[AddrW-1:0]), .wr_data(byte_value), .stat
  );

  fcgl_ctrl u_ctrl (
    .clk, .rst, .go, .cp, .len, .stat, .cmd(ccmd),
    .done, .glyph(glyph_id), .bad(malformed)
  );
endmodule

// ----- hdl/fcgl_checker.sv -----
// port-level checks for the glyph lookup
// depends on font_cmap_glyph_lookup_top through the top level binding
module fcgl_checker (
  input logic clk,
  input logic rst,
  input logic start,
  input logic busy,
  input logic mode,
  input logic done,
  input logic [31:0] glyph_id,
  input logic malformed
);
  a_done_busy: assert property (@(posedge clk) disable iff (rst) done |-> busy)
    else $error("done without request");
  a_lookup_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy && mode |=> busy) else $error("lookup not taken");
  a_load_nodone: assert property (@(posedge clk) disable iff (rst)
    start && !busy && !mode |=> !done) else $error("load gave a result");
  a_bad_zero: assert property (@(posedge clk) disable iff (rst)
    done && malformed |-> glyph_id == 32'd0) else $error("malformed with glyph");
endmodule

bind font_cmap_glyph_lookup_top fcgl_checker u_chk (.*);
